// ----- rtl/core/ola_pkg.sv -----
// Shared types, codes and defaults for the ordered list block.
package ola_pkg;

  // Default list depth.
  localparam int unsigned OLA_DEPTH = 16;

  // Fixed field widths.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  // Request operation codes.
  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                      append;
    logic                      delete_en;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- rtl/core/ola_cell.sv -----
// One storage cell of the list row: holds an entry and its valid bit.
module ola_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ola_pkg::cell_cmd_t                 cmd,
  input  logic                               hit_in,
  output logic                               hit_out,
  input  logic                               left_valid,
  input  logic signed [ola_pkg::VALUE_W-1:0] right_data,
  input  logic                               right_valid,
  output logic signed [ola_pkg::VALUE_W-1:0] data,
  output logic                               valid
);

  logic signed [ola_pkg::VALUE_W-1:0] data_r;
  logic signed [ola_pkg::VALUE_W-1:0] data_nxt;
  logic                               valid_r;
  logic                               valid_nxt;

  // Flag a match here or at any cell nearer the head.
  assign hit_out = hit_in | (valid_r & (data_r == cmd.value));

  // Take the appended value at the tail, or pull from the right neighbor
  // once the deleted entry lies at or before this cell.
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (cmd.append && !valid_r && left_valid) begin
      data_nxt  = cmd.value;
      valid_nxt = 1'b1;
    end else if (cmd.delete_en && hit_out) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end
  end

  // Clear the valid bit under reset; the entry itself needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

// ----- rtl/core/ordered_list_append_delete.sv -----
// Top level of the ordered list: a row of cells with append and delete.
//
//  channel | direction | ports                                         | handshake
//  in      | input     | in_operation, in_value                        | in_valid/in_ready
//  out     | output    | out_status, out_entry_count, out_head_value   | out_valid/out_ready
//
// One request is applied per cycle while not stalled: every cell compares against the
// value at once, a hit flag ripples down the row and the gap closes in a single shift.
// A result appears in the cycle after its request, in an output register.
// A new request is taken while the output register is empty or being emptied.
// A stall on the output side holds the input until the result is taken.
// Reset clears all valid bits and the fill count.
module ordered_list_append_delete #(
  parameter int unsigned DEPTH = ola_pkg::OLA_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [0:0]                         in_operation,
  input  logic signed [ola_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_status,
  output logic [ola_pkg::COUNT_W-1:0]        out_entry_count,
  output logic signed [ola_pkg::VALUE_W-1:0] out_head_value
);

  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  logic                               accept;
  ola_pkg::cell_cmd_t                 cmd;
  logic                               hit_chain [0:DEPTH];
  logic                               left_valid [0:DEPTH-1];
  logic signed [ola_pkg::VALUE_W-1:0] right_data [0:DEPTH-1];
  logic                               right_valid [0:DEPTH-1];
  logic signed [ola_pkg::VALUE_W-1:0] cell_data [0:DEPTH-1];
  logic                               cell_valid [0:DEPTH-1];

  logic [FILL_W-1:0]                  fill_r;
  logic [FILL_W-1:0]                  fill_nxt;
  logic                               is_full;
  logic                               is_empty;
  logic                               found;
  ola_pkg::status_t                   status_nxt;
  logic                               head_valid_nxt;
  logic signed [ola_pkg::VALUE_W-1:0] head_data_nxt;
  logic [FILL_W+ola_pkg::COUNT_W-1:0] fill_ext;

  logic                               out_valid_r;
  ola_pkg::status_t                   status_r;
  logic [ola_pkg::COUNT_W-1:0]        count_r;
  logic signed [ola_pkg::VALUE_W-1:0] head_r;

  // Accept a request whenever the output register can take its result.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_full  = cell_valid[DEPTH-1];
  assign is_empty = !cell_valid[0];

  // Broadcast the request to the row.
  always_comb begin
    cmd.append    = accept && (ola_pkg::op_t'(in_operation) == ola_pkg::OP_APPEND);
    cmd.delete_en = accept && (ola_pkg::op_t'(in_operation) == ola_pkg::OP_DELETE);
    cmd.value     = in_value;
  end

  assign hit_chain[0] = 1'b0;

  // Build the row; the last cell sees an empty right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_valid[i] = 1'b1;
    end else begin : g_inner
      assign left_valid[i] = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data[i]  = cell_data[i];
      assign right_valid[i] = 1'b0;
    end else begin : g_mid
      assign right_data[i]  = cell_data[i+1];
      assign right_valid[i] = cell_valid[i+1];
    end

    ola_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .hit_in      (hit_chain[i]),
      .hit_out     (hit_chain[i+1]),
      .left_valid  (left_valid[i]),
      .right_data  (right_data[i]),
      .right_valid (right_valid[i]),
      .data        (cell_data[i]),
      .valid       (cell_valid[i])
    );
  end

  assign found = hit_chain[DEPTH];

  // Decide status, next fill and next head.
  always_comb begin
    fill_nxt       = fill_r;
    status_nxt     = ola_pkg::ST_INSERTED;
    head_valid_nxt = cell_valid[0];
    head_data_nxt  = cell_data[0];
    if (ola_pkg::op_t'(in_operation) == ola_pkg::OP_APPEND) begin
      if (is_full) begin
        status_nxt = ola_pkg::ST_FULL;
      end else begin
        status_nxt = ola_pkg::ST_INSERTED;
        fill_nxt   = fill_r + FILL_W'(1);
        if (is_empty) begin
          head_valid_nxt = 1'b1;
          head_data_nxt  = in_value;
        end
      end
    end else begin
      if (is_empty) begin
        status_nxt = ola_pkg::ST_EMPTY;
      end else if (!found) begin
        status_nxt = ola_pkg::ST_NOT_FOUND;
      end else begin
        status_nxt = ola_pkg::ST_DELETED;
        fill_nxt   = fill_r - FILL_W'(1);
        if (hit_chain[1]) begin
          head_valid_nxt = right_valid[0];
          head_data_nxt  = right_data[0];
        end
      end
    end
  end

  // Mask the count to the field width.
  assign fill_ext = {{ola_pkg::COUNT_W{1'b0}}, fill_nxt};

  // Advance the fill count and the output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      count_r  <= fill_ext[ola_pkg::COUNT_W-1:0];
      head_r   <= head_valid_nxt ? head_data_nxt : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_count = count_r;
  assign out_head_value  = head_r;

endmodule

// ----- rtl/core/ola_checker.sv -----
// Port-level checks for the ordered list, bound to the top level.
module ola_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [2:0]                         out_status,
  input logic [ola_pkg::COUNT_W-1:0]        out_entry_count,
  input logic signed [ola_pkg::VALUE_W-1:0] out_head_value
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_entry_count) && $stable(out_head_value))
    else $error("result changed while stalled");

  // A request is always followed by a result in the next cycle.
  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("request gave no result");

  // An empty list reports no entries and a zero head.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ola_pkg::ST_EMPTY) |->
      (out_entry_count == '0) && (out_head_value == '0))
    else $error("empty status with entries");

  // Leaving reset shows no result.
  a_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind ordered_list_append_delete ola_checker u_ola_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_entry_count (out_entry_count),
  .out_head_value  (out_head_value)
);

// ----- sim/tb_top.sv -----
// Testbench for the ordered list block: scoreboard class, request and result drivers.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ola_pkg::*;

  localparam int unsigned LIST_DEPTH = OLA_DEPTH;
  localparam int STALL_MAX = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASE_ITEMS = 100;
  localparam int REPORT_MAX = 40;
  localparam int DRAIN_CYCLES = 8;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [0:0]                in_operation;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [2:0]                out_status;
  logic [COUNT_W-1:0]        out_entry_count;
  logic signed [VALUE_W-1:0] out_head_value;

  // Idle controls for the request and result sides
  bit in_gaps_on;
  bit out_stalls_on;
  bit hold_off;
  int quiet_cycles;

  // Track the list contents and the results each request must produce
  class list_scoreboard;
    typedef struct {
      logic [2:0]                status;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] head;
    } list_result_t;

    logic signed [VALUE_W-1:0] slots [LIST_DEPTH];
    int unsigned               fill;
    list_result_t              expected_results [$];
    int                        errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    // Apply an accepted request to the list and queue its result
    function void apply_request(op_t op, logic signed [VALUE_W-1:0] value);
      list_result_t r;
      int hit;
      hit = -1;
      if (op == OP_APPEND) begin
        if (fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[fill] = value;
          fill++;
          r.status = ST_INSERTED;
        end
      end else if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // Find the entry nearest the head, then close the gap
        for (int i = 0; i < int'(fill); i++) begin
          if (hit < 0 && slots[i] == value) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < int'(fill); i++) slots[i] = slots[i + 1];
          fill--;
          r.status = ST_DELETED;
        end
      end
      r.count = COUNT_W'(fill);
      r.head = (fill > 0) ? slots[0] : '0;
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      if (errors < REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one result, field by field, with the oldest expectation
    task check_result(logic [2:0] status, logic [COUNT_W-1:0] count,
                      logic signed [VALUE_W-1:0] head);
      list_result_t r;
      if (expected_results.size() == 0) begin
        report($sformatf("result with no request pending: status %0d count %0d head %0d",
                         status, count, head));
        return;
      end
      r = expected_results.pop_front();
      if (status !== r.status)
        report($sformatf("status %0d, expected %0d", status, r.status));
      if (count !== r.count)
        report($sformatf("entry count %0d, expected %0d", count, r.count));
      if (head !== r.head)
        report($sformatf("head value %0d, expected %0d", head, r.head));
    endtask
  endclass

  list_scoreboard sb = new();

  ordered_list_append_delete DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_head_value  (out_head_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Note requests and check results on every handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.apply_request(op_t'(in_operation), in_value);
      if (out_valid && out_ready) sb.check_result(out_status, out_entry_count, out_head_value);
    end
  end

  // Abort when no request or result moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one request, after a random gap if gaps are on, and hold it until accepted
  task automatic send_request(input op_t op, input logic signed [VALUE_W-1:0] value);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Cover empty, extremes, duplicates, absent values and a full list
  task automatic run_directed();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    send_request(OP_DELETE, 32'sd5);
    send_request(OP_APPEND, VALUE_MIN);
    send_request(OP_APPEND, VALUE_MAX);
    send_request(OP_APPEND, 32'sd0);
    send_request(OP_APPEND, -32'sd1);
    send_request(OP_APPEND, VALUE_MAX);
    send_request(OP_DELETE, VALUE_MAX);
    send_request(OP_DELETE, 32'sd12345);
    send_request(OP_DELETE, VALUE_MIN);
    for (int i = 0; i < 13; i++) send_request(OP_APPEND, 32'sd100 + i);
    send_request(OP_APPEND, 32'sd77);
    send_request(OP_DELETE, 32'sd112);
    send_request(OP_DELETE, -32'sd1);
  endtask

  // Random phases with a varying append mix so the list swings between empty and full
  task automatic run_random();
    logic signed [VALUE_W-1:0] pool [6];
    logic signed [VALUE_W-1:0] value;
    op_t                       op;
    int                        append_pct;
    int                        roll;
    for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
      foreach (pool[k]) pool[k] = $urandom;
      case (phase % 5)
        0: append_pct = 90;
        1: append_pct = 50;
        2: append_pct = 20;
        3: append_pct = 70;
        default: append_pct = 35;
      endcase
      in_gaps_on = ($urandom_range(0, 2) != 0);
      out_stalls_on = ($urandom_range(0, 2) != 0);
      // Stall the result side for a long stretch while requests are offered without gaps
      if (phase == 2) begin
        in_gaps_on = 1'b0;
        hold_off = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < append_pct) begin
          op = OP_APPEND;
          value = (roll < 75) ? pool[$urandom_range(0, 5)] : $urandom;
        end else begin
          op = OP_DELETE;
          if (roll < 50 && sb.fill > 0)
            value = sb.slots[$urandom_range(0, sb.fill - 1)];
          else if (roll < 85)
            value = pool[$urandom_range(0, 5)];
          else
            value = $urandom;
        end
        send_request(op, value);
      end
    end
  endtask

  // Result side: stall before taking each result, at random or on a hold-off
  initial begin : result_side
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off) begin
        stall = HOLD_CYCLES;
        hold_off = 1'b0;
      end else begin
        stall = out_stalls_on ? $urandom_range(0, STALL_MAX) : 0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Reset, drive all requests, drain and decide
  initial begin
    in_valid = 1'b0;
    in_operation = '0;
    in_value = '0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    hold_off = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ola_pkg.sv
rtl/core/ola_cell.sv
rtl/core/ordered_list_append_delete.sv
rtl/core/ola_checker.sv
sim/tb_top.sv
